// ----- sv/dtds_pkg.sv -----
package dtds_pkg;

  // Configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TARGET_COUNT = 2'd0,
    CFG_WRAP_MARGIN  = 2'd1,
    CFG_POINT_MODE   = 2'd2
  } dtds_cfg_e;

  // Input item actions
  localparam logic ActOffer   = 1'b0;
  localparam logic ActRestart = 1'b1;

  // Register reset values
  localparam logic [7:0]  TargetReset = 8'd100;
  localparam logic [15:0] MarginReset = 16'd6554;
  localparam logic        PointReset  = 1'b0;

  // Attempt budget: target times factor, saturated to the counter range
  localparam logic [14:0] AttemptFactor = 15'd100;
  localparam logic [13:0] AttemptsMax   = 14'd16383;

  // Stored entry: x, y, radius
  localparam int unsigned EntryW = 48;

  typedef struct packed {
    logic        action;
    logic [15:0] cand_x;
    logic [15:0] cand_y;
    logic [15:0] cand_radius;
  } dtds_in_t;

  typedef struct packed {
    logic       accepted;
    logic [7:0] placed_count;
    logic       finished;
  } dtds_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic issue;
    logic store;
    logic use_attempt;
    logic restart;
    logic out_load;
  } dtds_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic restart_req;
    logic finished;
    logic table_empty;
    logic last_issue;
    logic pipe_busy;
    logic hit;
    logic out_free;
  } dtds_sts_t;

  function automatic logic [13:0] reload_attempts(input logic [7:0] target);
    logic [14:0] prod;
    prod = 15'(target) * AttemptFactor;
    if (prod > 15'(AttemptsMax)) begin
      return AttemptsMax;
    end else begin
      return prod[13:0];
    end
  endfunction

endpackage

// ----- sv/dart_throwing_disk_sampler.sv -----
// Flow: each item is captured and checked, the table is swept, the sweep
//   pipeline drained, the result committed and loaded into the output
//   register; restart, ignored offers and empty-table offers skip the sweep.
// Throughput: one item at a time; the sweep reads one table entry per cycle
//   through the single read port and tests its plain and wrapped copies at once.
// Reset: counters cleared, attempt budget and registers at reset values,
//   disk table left unwritten (no clearing pass).
module dart_throwing_disk_sampler #(
  parameter int unsigned MAX_DISKS  = 128,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dtds_pkg::dtds_in_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dtds_pkg::dtds_out_t           out_data_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dtds_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dtds_pkg::CfgDataW-1:0] cfg_data_i
);
  import dtds_pkg::*;

  dtds_cmd_t cmd;
  dtds_sts_t sts;

  dtds_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dtds_datapath #(
    .MAX_DISKS  (MAX_DISKS),
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cmd_i       (cmd),
    .sts_o       (sts)
  );

endmodule

// ----- sv/dtds_ctrl.sv -----
module dtds_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  dtds_pkg::dtds_sts_t sts_i,
  output dtds_pkg::dtds_cmd_t cmd_o
);
  import dtds_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CHECK  = 6'b000010,
    ST_SWEEP  = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_COMMIT = 6'b010000,
    ST_REPLY  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // Take a new item only when no item is in flight
  assign in_stall_o = (state_q != ST_IDLE);

  // Sequence one item: route, sweep the table, commit, hand off the result
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (sts_i.restart_req || sts_i.finished || sts_i.table_empty) begin
          state_d = ST_COMMIT;
        end else begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        cmd_o.issue = 1'b1;
        if (sts_i.last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        if (sts_i.restart_req) begin
          cmd_o.restart = 1'b1;
        end else if (!sts_i.finished) begin
          cmd_o.use_attempt = 1'b1;
          cmd_o.store       = !sts_i.hit;
        end
        state_d = ST_REPLY;
      end
      ST_REPLY: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- sv/dtds_datapath.sv -----
module dtds_datapath #(
  parameter int unsigned MAX_DISKS  = 128,
  parameter int unsigned COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dtds_pkg::CfgIdxW-1:0]      cfg_index_i,
  input  logic [dtds_pkg::CfgDataW-1:0]     cfg_data_i,
  input  dtds_pkg::dtds_in_t                in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output dtds_pkg::dtds_out_t               out_data_o,
  input  dtds_pkg::dtds_cmd_t               cmd_i,
  output dtds_pkg::dtds_sts_t               sts_o
);
  import dtds_pkg::*;

  localparam int unsigned AW      = $clog2(MAX_DISKS);
  localparam int unsigned CntW    = $clog2(MAX_DISKS + 1);
  localparam int unsigned CmpW    = (CntW > 8) ? CntW : 8;
  localparam int unsigned CW      = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam int unsigned MW      = CW - 1;
  localparam int unsigned PW      = 2 * MW;
  localparam int unsigned SW      = PW + 1;
  localparam int unsigned RW      = 17;
  localparam int unsigned MaskBits = (COORD_BITS < 16) ? COORD_BITS : 16;
  localparam logic [15:0] CoordMask = 16'((32'd1 << MaskBits) - 32'd1);
  localparam logic [CW-1:0] CoordOne = CW'(1) << COORD_BITS;

  // Configuration registers
  logic [7:0]  target_q;
  logic [15:0] margin_q;
  logic        point_q;

  // Counters and control flags
  logic [CntW-1:0] stored_q;
  logic [13:0]     attempts_q;
  logic [AW-1:0]   idx_q;
  logic            acc_q;
  logic            hit_q;
  logic            v1_q, v2_q, v3_q;
  logic            out_valid_q;
  dtds_out_t       out_data_q;

  // Candidate
  logic          action_q;
  logic [15:0]   cx_q, cy_q, cr_q;
  logic [CW-1:0] cxw_q, cyw_q;
  logic          xw_en_q, yw_en_q;

  // Disk table and sweep pipeline
  logic [EntryW-1:0] disk_mem [MAX_DISKS];
  logic [EntryW-1:0] rd_q;
  logic [MW-1:0]     adx_q, adxw_q, ady_q, adyw_q;
  logic [RW-1:0]     reach_q;
  logic [PW-1:0]     sx_q, sxw_q, sy_q, syw_q;
  logic [2*RW-1:0]   rr_q;

  logic          finished;
  logic [15:0]   x_m, y_m;
  logic [CW-1:0] x_ext, y_ext, margin_ext;
  logic          xw_lo, xw_hi, yw_lo, yw_hi;
  logic [CW-1:0] xw_val, yw_val;

  logic signed [CW-1:0] dx_s, dxw_s, dy_s, dyw_s;
  logic [MW-1:0]        adx_d, adxw_d, ady_d, adyw_d;
  logic [RW-1:0]        reach_d;
  logic [SW-1:0]        rr_ext;
  logic                 hit_now;

  assign cfg_ready_o = 1'b1;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q <= TargetReset;
      margin_q <= MarginReset;
      point_q  <= PointReset;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_TARGET_COUNT: target_q <= cfg_data_i[7:0];
        CFG_WRAP_MARGIN:  margin_q <= cfg_data_i[15:0];
        CFG_POINT_MODE:   point_q  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Sampling is done on target, attempt budget or a full table
  assign finished = (attempts_q == '0) ||
                    (CmpW'(stored_q) >= CmpW'(target_q)) ||
                    (stored_q >= CntW'(MAX_DISKS));

  // Mask the candidate and pick its wrapped copies
  assign x_m        = in_data_i.cand_x & CoordMask;
  assign y_m        = in_data_i.cand_y & CoordMask;
  assign x_ext      = CW'(x_m);
  assign y_ext      = CW'(y_m);
  assign margin_ext = CW'(margin_q);
  assign xw_lo      = x_ext < margin_ext;
  assign xw_hi      = (CoordOne - x_ext) < margin_ext;
  assign yw_lo      = y_ext < margin_ext;
  assign yw_hi      = (CoordOne - y_ext) < margin_ext;
  assign xw_val     = xw_lo ? (x_ext + CoordOne) : (x_ext - CoordOne);
  assign yw_val     = yw_lo ? (y_ext + CoordOne) : (y_ext - CoordOne);

  // Capture the candidate on transfer
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      action_q <= in_data_i.action;
      cx_q     <= x_m;
      cy_q     <= y_m;
      cr_q     <= in_data_i.cand_radius;
      cxw_q    <= xw_val;
      cyw_q    <= yw_val;
      xw_en_q  <= xw_lo || xw_hi;
      yw_en_q  <= yw_lo || yw_hi;
    end
  end

  // Table write on store, registered read on sweep
  always_ff @(posedge clk_i) begin
    if (cmd_i.store) begin
      disk_mem[stored_q[AW-1:0]] <= {cx_q, cy_q, cr_q};
    end
    if (cmd_i.issue) begin
      rd_q <= disk_mem[idx_q];
    end
  end

  // Stage 1: differences to the stored centre, and the reach
  assign dx_s  = $signed(CW'(rd_q[47:32])) - $signed(CW'(cx_q));
  assign dxw_s = $signed(CW'(rd_q[47:32])) - $signed(cxw_q);
  assign dy_s  = $signed(CW'(rd_q[31:16])) - $signed(CW'(cy_q));
  assign dyw_s = $signed(CW'(rd_q[31:16])) - $signed(cyw_q);
  assign adx_d  = dx_s[CW-1]  ? MW'(-dx_s)  : MW'(dx_s);
  assign adxw_d = dxw_s[CW-1] ? MW'(-dxw_s) : MW'(dxw_s);
  assign ady_d  = dy_s[CW-1]  ? MW'(-dy_s)  : MW'(dy_s);
  assign adyw_d = dyw_s[CW-1] ? MW'(-dyw_s) : MW'(dyw_s);
  assign reach_d = point_q ? RW'(rd_q[15:0]) : (RW'(rd_q[15:0]) + RW'(cr_q));

  always_ff @(posedge clk_i) begin
    if (v1_q) begin
      adx_q   <= adx_d;
      adxw_q  <= adxw_d;
      ady_q   <= ady_d;
      adyw_q  <= adyw_d;
      reach_q <= reach_d;
    end
  end

  // Stage 2: squares
  always_ff @(posedge clk_i) begin
    if (v2_q) begin
      sx_q  <= PW'(adx_q) * PW'(adx_q);
      sxw_q <= PW'(adxw_q) * PW'(adxw_q);
      sy_q  <= PW'(ady_q) * PW'(ady_q);
      syw_q <= PW'(adyw_q) * PW'(adyw_q);
      rr_q  <= (2*RW)'(reach_q) * (2*RW)'(reach_q);
    end
  end

  // Stage 3: distance against reach for the plain and wrapped copies
  assign rr_ext  = SW'(rr_q);
  assign hit_now = v3_q && (
                     ((SW'(sx_q) + SW'(sy_q)) <= rr_ext) ||
                     (xw_en_q && ((SW'(sxw_q) + SW'(sy_q)) <= rr_ext)) ||
                     (yw_en_q && ((SW'(sx_q) + SW'(syw_q)) <= rr_ext)));

  // Counters, sweep index, pipeline valids and hit flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stored_q   <= '0;
      attempts_q <= reload_attempts(TargetReset);
      idx_q      <= '0;
      acc_q      <= 1'b0;
      hit_q      <= 1'b0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
    end else begin
      if (cmd_i.restart) begin
        stored_q   <= '0;
        attempts_q <= reload_attempts(target_q);
      end else begin
        if (cmd_i.store) begin
          stored_q <= stored_q + CntW'(1);
        end
        if (cmd_i.use_attempt) begin
          attempts_q <= attempts_q - 14'd1;
        end
      end
      if (cmd_i.load) begin
        idx_q <= '0;
        acc_q <= 1'b0;
        hit_q <= 1'b0;
      end else begin
        if (cmd_i.issue) begin
          idx_q <= idx_q + AW'(1);
        end
        if (cmd_i.store) begin
          acc_q <= 1'b1;
        end
        if (hit_now) begin
          hit_q <= 1'b1;
        end
      end
      v1_q <= cmd_i.issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  // Output register: hold the result until transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_data_q.accepted     <= acc_q;
      out_data_q.placed_count <= 8'(stored_q);
      out_data_q.finished     <= finished;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // Status
  assign sts_o.restart_req = (action_q == ActRestart);
  assign sts_o.finished    = finished;
  assign sts_o.table_empty = (stored_q == '0);
  assign sts_o.last_issue  = ((CntW'(idx_q) + CntW'(1)) == stored_q);
  assign sts_o.pipe_busy   = v1_q || v2_q || v3_q;
  assign sts_o.hit         = hit_q;
  assign sts_o.out_free    = !out_valid_q || !out_stall_i;

`ifndef SYNTHESIS
  a_stored_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stored_q <= CntW'(MAX_DISKS))
    else $error("stored count beyond table depth");

  a_store_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |-> (!finished && !hit_q && !sts_o.pipe_busy))
    else $error("store while finished, hit or sweep in flight");

  a_issue_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.issue |-> (CntW'(idx_q) < stored_q))
    else $error("sweep read beyond stored entries");

  a_store_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.store |=> (stored_q == $past(stored_q) + CntW'(1)) && acc_q)
    else $error("store did not advance count");

  a_load_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> !sts_o.pipe_busy)
    else $error("new item while sweep pipeline busy");
`endif

endmodule
